### hdl/ibrm_pkg.sv
// package: item types, opcodes, configuration codes and reset values
package ibrm_pkg;

  localparam int REGISTER_COUNT_DEFAULT = 6;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_POINTER_REGISTER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROGRAM_LENGTH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WATCH_REGISTER   = 2'd2;

  localparam logic [2:0]  POINTER_REGISTER_RESET = 3'd0;
  localparam logic [15:0] PROGRAM_LENGTH_RESET   = 16'd32;
  localparam logic [2:0]  WATCH_REGISTER_RESET   = 3'd5;

  localparam logic MODE_EXECUTE = 1'b0;
  localparam logic MODE_LOAD    = 1'b1;

  localparam logic [3:0] OP_ADDR = 4'd0;
  localparam logic [3:0] OP_ADDI = 4'd1;
  localparam logic [3:0] OP_MULR = 4'd2;
  localparam logic [3:0] OP_MULI = 4'd3;
  localparam logic [3:0] OP_BANR = 4'd4;
  localparam logic [3:0] OP_BANI = 4'd5;
  localparam logic [3:0] OP_BORR = 4'd6;
  localparam logic [3:0] OP_BORI = 4'd7;
  localparam logic [3:0] OP_SETR = 4'd8;
  localparam logic [3:0] OP_SETI = 4'd9;
  localparam logic [3:0] OP_GTIR = 4'd10;
  localparam logic [3:0] OP_GTRI = 4'd11;
  localparam logic [3:0] OP_GTRR = 4'd12;
  localparam logic [3:0] OP_EQIR = 4'd13;
  localparam logic [3:0] OP_EQRI = 4'd14;
  localparam logic [3:0] OP_EQRR = 4'd15;

  typedef struct packed {
    logic              mode;
    logic [3:0]        opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic [2:0]        operand_c;
  } in_t;

  typedef struct packed {
    logic signed [31:0] next_pointer;
    logic              halted;
    logic              bad_index;
    logic signed [31:0] written_value;
    logic signed [31:0] watched_value;
  } out_t;

endpackage

### hdl/ip_bound_register_machine_step.sv
// top level: toy cpu execute step with register file and bound instruction pointer
// throughput: one item per cycle while out_ready does not stall the result side;
// the register file read, alu and write-back share one execute stage between
// the input register and the result register
// reset: register file cleared, pointer register 0, program length 32, watch 5
// reset empties both stages; configuration writes take effect at the next edge
module ip_bound_register_machine_step #(
  parameter int REGISTER_COUNT = ibrm_pkg::REGISTER_COUNT_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ibrm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ibrm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ibrm_pkg::in_t                    in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ibrm_pkg::out_t                   out_item
);

  localparam int IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam logic [31:0] REG_COUNT32 = 32'(REGISTER_COUNT);

  logic [2:0]  pointer_register;
  logic [15:0] program_length;
  logic [2:0]  watch_register;

  logic          s1_valid;
  ibrm_pkg::in_t s1_item;
  logic [REGISTER_COUNT-1:0][31:0] rf;
  logic [REGISTER_COUNT-1:0][31:0] rf_next;

  logic advance;
  logic a_reg, b_reg;
  logic a_ok, b_ok, c_ok, ptr_ok, watch_ok, bad;
  logic [31:0] c_ext, ptr_ext, watch_ext;
  logic [IDX_W-1:0] a_idx, b_idx, c_idx, p_idx, w_idx;
  logic [31:0] ra, rb, alu_val, write_val, inc_val, ptr_now;
  ibrm_pkg::out_t result;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_comb begin
    case (s1_item.opcode)
      ibrm_pkg::OP_ADDR, ibrm_pkg::OP_MULR, ibrm_pkg::OP_BANR, ibrm_pkg::OP_BORR,
      ibrm_pkg::OP_GTRR, ibrm_pkg::OP_EQRR: begin
        a_reg = 1'b1;
        b_reg = 1'b1;
      end
      ibrm_pkg::OP_ADDI, ibrm_pkg::OP_MULI, ibrm_pkg::OP_BANI, ibrm_pkg::OP_BORI,
      ibrm_pkg::OP_SETR, ibrm_pkg::OP_GTRI, ibrm_pkg::OP_EQRI: begin
        a_reg = 1'b1;
        b_reg = 1'b0;
      end
      ibrm_pkg::OP_GTIR, ibrm_pkg::OP_EQIR: begin
        a_reg = 1'b0;
        b_reg = 1'b1;
      end
      default: begin
        a_reg = 1'b0;
        b_reg = 1'b0;
      end
    endcase
  end

  assign c_ext     = {29'b0, s1_item.operand_c};
  assign ptr_ext   = {29'b0, pointer_register};
  assign watch_ext = {29'b0, watch_register};

  assign a_ok     = $unsigned(s1_item.operand_a) < REG_COUNT32;
  assign b_ok     = $unsigned(s1_item.operand_b) < REG_COUNT32;
  assign c_ok     = c_ext < REG_COUNT32;
  assign ptr_ok   = ptr_ext < REG_COUNT32;
  assign watch_ok = watch_ext < REG_COUNT32;

  assign a_idx = s1_item.operand_a[IDX_W-1:0];
  assign b_idx = s1_item.operand_b[IDX_W-1:0];
  assign c_idx = c_ext[IDX_W-1:0];
  assign p_idx = ptr_ext[IDX_W-1:0];
  assign w_idx = watch_ext[IDX_W-1:0];

  assign bad = !c_ok || !ptr_ok ||
               ((s1_item.mode == ibrm_pkg::MODE_EXECUTE) &&
                ((a_reg && !a_ok) || (b_reg && !b_ok)));

  assign ra = a_ok ? rf[a_idx] : 32'b0;
  assign rb = b_ok ? rf[b_idx] : 32'b0;

  ibrm_alu u_alu (
    .opcode (s1_item.opcode),
    .ra     (ra),
    .rb     (rb),
    .ia     (s1_item.operand_a),
    .ib     (s1_item.operand_b),
    .result (alu_val)
  );

  assign write_val = (s1_item.mode == ibrm_pkg::MODE_LOAD) ? s1_item.operand_a : alu_val;
  // pointer increment sees the destination write first
  assign inc_val = ((c_idx == p_idx) ? write_val : rf[p_idx]) + 32'd1;

  always_comb begin
    for (int i = 0; i < REGISTER_COUNT; i++) begin
      rf_next[i] = rf[i];
      if (!bad && c_idx == IDX_W'(i)) begin
        rf_next[i] = write_val;
      end
      if (!bad && s1_item.mode == ibrm_pkg::MODE_EXECUTE && p_idx == IDX_W'(i)) begin
        rf_next[i] = inc_val;
      end
    end
  end

  assign ptr_now = ptr_ok ? rf_next[p_idx] : 32'b0;

  always_comb begin
    result.next_pointer  = ptr_now;
    result.halted        = ptr_now[31] || (ptr_now >= {16'b0, program_length});
    result.bad_index     = bad;
    result.written_value = bad ? 32'sb0 : write_val;
    result.watched_value = watch_ok ? rf_next[w_idx] : 32'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pointer_register <= ibrm_pkg::POINTER_REGISTER_RESET;
      program_length   <= ibrm_pkg::PROGRAM_LENGTH_RESET;
      watch_register   <= ibrm_pkg::WATCH_REGISTER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ibrm_pkg::CFG_POINTER_REGISTER: pointer_register <= cfg_data[2:0];
        ibrm_pkg::CFG_PROGRAM_LENGTH:   program_length   <= cfg_data;
        ibrm_pkg::CFG_WATCH_REGISTER:   watch_register   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      rf        <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        rf        <= rf_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
    if (advance) begin
      out_item <= result;
    end
  end

  a_bad_writes_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.bad_index |-> out_item.written_value == 32'sb0)
    else $error("bad index item reports a nonzero written value");

  a_idle_rf_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(rf))
    else $error("register file changed without an item");

  a_bad_rf_holds: assert property (@(posedge clk) disable iff (rst)
    advance && bad |=> $stable(rf))
    else $error("register file changed on a bad index item");

  a_halted_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.halted == (out_item.next_pointer[31] ||
      ($unsigned(out_item.next_pointer) >= {16'b0, program_length})))
    else $error("halted flag disagrees with next pointer");

endmodule

### hdl/ibrm_alu.sv
// alu: evaluates one of the sixteen opcodes on register and immediate operands
module ibrm_alu (
  input  logic [3:0]  opcode,
  input  logic [31:0] ra,
  input  logic [31:0] rb,
  input  logic [31:0] ia,
  input  logic [31:0] ib,
  output logic [31:0] result
);

  always_comb begin
    case (opcode)
      ibrm_pkg::OP_ADDR: result = ra + rb;
      ibrm_pkg::OP_ADDI: result = ra + ib;
      ibrm_pkg::OP_MULR: result = ra * rb;
      ibrm_pkg::OP_MULI: result = ra * ib;
      ibrm_pkg::OP_BANR: result = ra & rb;
      ibrm_pkg::OP_BANI: result = ra & ib;
      ibrm_pkg::OP_BORR: result = ra | rb;
      ibrm_pkg::OP_BORI: result = ra | ib;
      ibrm_pkg::OP_SETR: result = ra;
      ibrm_pkg::OP_SETI: result = ia;
      ibrm_pkg::OP_GTIR: result = {31'b0, $signed(ia) > $signed(rb)};
      ibrm_pkg::OP_GTRI: result = {31'b0, $signed(ra) > $signed(ib)};
      ibrm_pkg::OP_GTRR: result = {31'b0, $signed(ra) > $signed(rb)};
      ibrm_pkg::OP_EQIR: result = {31'b0, ia == rb};
      ibrm_pkg::OP_EQRI: result = {31'b0, ra == ib};
      ibrm_pkg::OP_EQRR: result = {31'b0, ra == rb};
      default:           result = 32'b0;
    endcase
  end

endmodule

### tb/sv/tb_ip_bound_register_machine_step.sv
// testbench for ip_bound_register_machine_step: directed and random instructions, scoreboard check
`timescale 1ns / 100ps

module tb_ip_bound_register_machine_step;

  localparam int REGS           = ibrm_pkg::REGISTER_COUNT_DEFAULT;
  localparam int IDX_W          = $clog2(REGS);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 60;

  class exec_scoreboard;
    logic [31:0]    regs [REGS];
    logic [2:0]     ptr_sel;
    logic [15:0]    prog_len;
    logic [2:0]     watch_sel;
    ibrm_pkg::out_t results_due [$];
    int             errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      ptr_sel   = ibrm_pkg::POINTER_REGISTER_RESET;
      prog_len  = ibrm_pkg::PROGRAM_LENGTH_RESET;
      watch_sel = ibrm_pkg::WATCH_REGISTER_RESET;
      errors    = 0;
    endfunction

    function void configure(logic [ibrm_pkg::CFG_INDEX_W-1:0] idx,
                            logic [ibrm_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        ibrm_pkg::CFG_POINTER_REGISTER: ptr_sel = data[2:0];
        ibrm_pkg::CFG_PROGRAM_LENGTH:   prog_len = data[15:0];
        ibrm_pkg::CFG_WATCH_REGISTER:   watch_sel = data[2:0];
        default: ;
      endcase
    endfunction

    function bit index_ok(logic [31:0] v);
      return v < REGS;
    endfunction

    function logic [31:0] read_reg(logic [31:0] v);
      return index_ok(v) ? regs[v[IDX_W-1:0]] : 32'd0;
    endfunction

    function ibrm_pkg::out_t execute_step(ibrm_pkg::in_t it);
      bit             reads_a;
      bit             reads_b;
      bit             bad;
      logic [31:0]    ia;
      logic [31:0]    ib;
      logic [31:0]    ra;
      logic [31:0]    rb;
      logic [31:0]    val;
      logic [31:0]    ptr;
      ibrm_pkg::out_t res;
      reads_a = 1'b0;
      reads_b = 1'b0;
      val = '0;
      ia = it.operand_a;
      ib = it.operand_b;
      case (it.opcode)
        ibrm_pkg::OP_ADDR, ibrm_pkg::OP_MULR, ibrm_pkg::OP_BANR, ibrm_pkg::OP_BORR,
        ibrm_pkg::OP_GTRR, ibrm_pkg::OP_EQRR: begin
          reads_a = 1'b1;
          reads_b = 1'b1;
        end
        ibrm_pkg::OP_ADDI, ibrm_pkg::OP_MULI, ibrm_pkg::OP_BANI, ibrm_pkg::OP_BORI,
        ibrm_pkg::OP_SETR, ibrm_pkg::OP_GTRI, ibrm_pkg::OP_EQRI: reads_a = 1'b1;
        ibrm_pkg::OP_GTIR, ibrm_pkg::OP_EQIR: reads_b = 1'b1;
        default: ;
      endcase
      bad = !index_ok({29'd0, it.operand_c}) || !index_ok({29'd0, ptr_sel});
      if (it.mode == ibrm_pkg::MODE_EXECUTE) begin
        if (reads_a && !index_ok(ia)) bad = 1'b1;
        if (reads_b && !index_ok(ib)) bad = 1'b1;
      end
      if (!bad) begin
        if (it.mode == ibrm_pkg::MODE_LOAD) begin
          val = ia;
          regs[it.operand_c] = val;
        end else begin
          ra = read_reg(ia);
          rb = read_reg(ib);
          case (it.opcode)
            ibrm_pkg::OP_ADDR: val = ra + rb;
            ibrm_pkg::OP_ADDI: val = ra + ib;
            ibrm_pkg::OP_MULR: val = ra * rb;
            ibrm_pkg::OP_MULI: val = ra * ib;
            ibrm_pkg::OP_BANR: val = ra & rb;
            ibrm_pkg::OP_BANI: val = ra & ib;
            ibrm_pkg::OP_BORR: val = ra | rb;
            ibrm_pkg::OP_BORI: val = ra | ib;
            ibrm_pkg::OP_SETR: val = ra;
            ibrm_pkg::OP_SETI: val = ia;
            ibrm_pkg::OP_GTIR: val = ($signed(ia) > $signed(rb)) ? 32'd1 : 32'd0;
            ibrm_pkg::OP_GTRI: val = ($signed(ra) > $signed(ib)) ? 32'd1 : 32'd0;
            ibrm_pkg::OP_GTRR: val = ($signed(ra) > $signed(rb)) ? 32'd1 : 32'd0;
            ibrm_pkg::OP_EQIR: val = (ia == rb) ? 32'd1 : 32'd0;
            ibrm_pkg::OP_EQRI: val = (ra == ib) ? 32'd1 : 32'd0;
            default: val = (ra == rb) ? 32'd1 : 32'd0;
          endcase
          regs[it.operand_c] = val;
          regs[ptr_sel] = regs[ptr_sel] + 32'd1;
        end
      end
      ptr = read_reg({29'd0, ptr_sel});
      res.next_pointer  = ptr;
      res.halted        = ptr[31] || (ptr >= {16'd0, prog_len});
      res.bad_index     = bad;
      res.written_value = bad ? 32'd0 : val;
      res.watched_value = read_reg({29'd0, watch_sel});
      return res;
    endfunction

    function void note_input(ibrm_pkg::in_t it);
      ibrm_pkg::out_t want;
      want = execute_step(it);
      results_due.insert(results_due.size(), want);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(ibrm_pkg::out_t got);
      ibrm_pkg::out_t want;
      if (results_due.size() == 0) begin
        report("result with no item outstanding");
        return;
      end
      want = results_due.pop_front();
      if (got.next_pointer !== want.next_pointer)
        report($sformatf("next_pointer %0d, want %0d", got.next_pointer, want.next_pointer));
      if (got.halted !== want.halted)
        report($sformatf("halted %0b, want %0b", got.halted, want.halted));
      if (got.bad_index !== want.bad_index)
        report($sformatf("bad_index %0b, want %0b", got.bad_index, want.bad_index));
      if (got.written_value !== want.written_value)
        report($sformatf("written_value %0d, want %0d", got.written_value,
                         want.written_value));
      if (got.watched_value !== want.watched_value)
        report($sformatf("watched_value %0d, want %0d", got.watched_value,
                         want.watched_value));
    endtask
  endclass

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             cfg_write = 1'b0;
  logic [ibrm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ibrm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  ibrm_pkg::in_t                    in_item = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  ibrm_pkg::out_t                   out_item;

  exec_scoreboard sb;
  bit             no_idle = 1'b0;
  bit             hold_request = 1'b0;
  int             quiet_cycles = 0;

  ip_bound_register_machine_step dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(in_item);
      if (out_valid && out_ready) sb.check_result(out_item);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side
  initial begin
    int gap;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic ibrm_pkg::in_t mk(logic mode, logic [3:0] op, logic [31:0] a,
                                       logic [31:0] b, logic [2:0] c);
    ibrm_pkg::in_t it;
    it.mode      = mode;
    it.opcode    = op;
    it.operand_a = a;
    it.operand_b = b;
    it.operand_c = c;
    return it;
  endfunction

  function automatic logic [31:0] random_operand();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 78) return $urandom_range(0, REGS - 1);
    if (pick < 86) return $urandom;
    if (pick < 92) return $urandom_range(0, 20) - 10;
    if (pick < 97) begin
      case ($urandom_range(0, 3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'hffff_ffff;
        default: return 32'd0;
      endcase
    end
    return $urandom_range(6, 7);
  endfunction

  function automatic ibrm_pkg::in_t random_instruction();
    ibrm_pkg::in_t it;
    it.mode      = ($urandom_range(0, 9) == 0) ? ibrm_pkg::MODE_LOAD : ibrm_pkg::MODE_EXECUTE;
    it.opcode    = 4'($urandom_range(0, 15));
    it.operand_a = random_operand();
    it.operand_b = random_operand();
    it.operand_c = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, REGS - 1));
    // park the pointer just around the program end
    if (it.mode == ibrm_pkg::MODE_LOAD && $urandom_range(0, 1) == 1) begin
      it.operand_c = sb.ptr_sel;
      it.operand_a = {16'd0, sb.prog_len} + $urandom_range(0, 4) - 3;
    end
    return it;
  endfunction

  task automatic send_item(ibrm_pkg::in_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(logic [2:0] ptr, logic [15:0] len, logic [2:0] watch);
    cfg_write <= 1'b1;
    cfg_index <= ibrm_pkg::CFG_POINTER_REGISTER;
    cfg_data  <= {13'd0, ptr};
    @(posedge clk);
    cfg_index <= ibrm_pkg::CFG_PROGRAM_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    cfg_index <= ibrm_pkg::CFG_WATCH_REGISTER;
    cfg_data  <= {13'd0, watch};
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.configure(ibrm_pkg::CFG_POINTER_REGISTER, {13'd0, ptr});
    sb.configure(ibrm_pkg::CFG_PROGRAM_LENGTH, len);
    sb.configure(ibrm_pkg::CFG_WATCH_REGISTER, {13'd0, watch});
  endtask

  task automatic run_phase(logic [2:0] ptr, logic [15:0] len, logic [2:0] watch, int count,
                           bit quiet, bit hold);
    wait_idle();
    write_config(ptr, len, watch);
    no_idle      = quiet;
    hold_request = hold;
    repeat (count) send_item(random_instruction());
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes into the register file
    send_item(mk(ibrm_pkg::MODE_LOAD, ibrm_pkg::OP_EQRR, 32'h7fff_ffff, 32'hffff_ffff, 3'd1));
    send_item(mk(ibrm_pkg::MODE_LOAD, ibrm_pkg::OP_ADDR, 32'h8000_0000, 32'd0, 3'd2));
    send_item(mk(ibrm_pkg::MODE_LOAD, ibrm_pkg::OP_SETI, 32'hffff_ffff, 32'h8000_0000, 3'd3));
    send_item(mk(ibrm_pkg::MODE_LOAD, ibrm_pkg::OP_GTIR, 32'd3, 32'd77, 3'd4));
    // every opcode
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_ADDR, 32'd1, 32'd2, 3'd5));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_ADDI, 32'd1, 32'd1, 3'd5));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_MULR, 32'd1, 32'd1, 3'd5));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_MULI, 32'd4, 32'h8000_0001, 3'd5));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_BANR, 32'd2, 32'd3, 3'd5));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_BANI, 32'd3, 32'h0f0f_0f0f, 3'd5));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_BORR, 32'd1, 32'd2, 3'd5));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_BORI, 32'd4, 32'h8000_0000, 3'd5));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_SETR, 32'd3, 32'hffff_fff9, 3'd4));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_SETI, 32'h8000_0000, 32'd99, 3'd5));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_GTIR, 32'hffff_fffe, 32'd3, 3'd5));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_GTRI, 32'd1, 32'hffff_ffff, 3'd5));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_GTRR, 32'd1, 32'd2, 3'd5));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_EQIR, 32'hffff_ffff, 32'd3, 3'd5));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_EQRI, 32'd2, 32'h8000_0000, 3'd5));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_EQRR, 32'd3, 32'd3, 3'd5));
    // bad indices: destination, negative source, second source
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_ADDR, 32'd1, 32'd2, 3'd6));
    send_item(mk(ibrm_pkg::MODE_LOAD, ibrm_pkg::OP_BORI, 32'd5, 32'd0, 3'd7));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_ADDR, 32'hffff_ffff, 32'd0, 3'd1));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_EQRR, 32'd0, 32'd6, 3'd1));
    // pointer register as destination, then past the end and negative
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_ADDI, 32'd0, 32'd40, 3'd0));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_ADDR, 32'd2, 32'd2, 3'd2));
    send_item(mk(ibrm_pkg::MODE_LOAD, ibrm_pkg::OP_ADDR, 32'hffff_fffd, 32'd0, 3'd0));
    send_item(mk(ibrm_pkg::MODE_LOAD, ibrm_pkg::OP_ADDR, 32'd31, 32'd0, 3'd0));
    send_item(mk(ibrm_pkg::MODE_EXECUTE, ibrm_pkg::OP_SETI, 32'd7, 32'd0, 3'd3));

    run_phase(3'd0, 16'd8, 3'd5, 150, 1'b0, 1'b0);
    run_phase(3'd5, 16'd0, 3'd0, 120, 1'b1, 1'b1);
    run_phase(3'd3, 16'hffff, 3'd3, 120, 1'b0, 1'b0);
    run_phase(3'd7, 16'd32, 3'd6, 60, 1'b0, 1'b0);
    run_phase(3'd2, 16'd1, 3'd1, 120, 1'b1, 1'b0);
    run_phase(3'($urandom_range(0, 5)), 16'($urandom_range(0, 40)),
              3'($urandom_range(0, 7)), 150, 1'b0, 1'b0);
    run_phase(3'd1, 16'd20, 3'd2, 150, 1'b0, 1'b1);
    run_phase(3'd4, 16'd10, 3'd4, 130, 1'b0, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
hdl/ibrm_pkg.sv
hdl/ibrm_alu.sv
hdl/ip_bound_register_machine_step.sv
tb/sv/tb_ip_bound_register_machine_step.sv
